// ===== hdl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
// Holds the item and result records, the sequencer phase encoding and the status codes.
// No dependencies.
package i2cm_pkg;

	localparam int unsigned HALF_W = 16;
	localparam int unsigned TMO_W  = 20;
	localparam int unsigned CFG_W  = 20;

	localparam logic [HALF_W-1:0] HALF_RESET = 16'd50;
	localparam logic [TMO_W-1:0]  TMO_RESET  = 20'd1000;

	localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
	localparam logic [3:0] RECOVER_PULSES = 4'd9;

	typedef enum logic [0:0] {
		REG_HALF_PERIOD = 1'b0,
		REG_STRETCH_TMO = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		CMD_START   = 3'd0,
		CMD_STOP    = 3'd1,
		CMD_WRITE   = 3'd2,
		CMD_READ    = 3'd3,
		CMD_RECOVER = 3'd4
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NACK    = 2'd1,
		ST_TIMEOUT = 2'd2,
		ST_BUSY    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		KIND_TICK    = 3'd0,
		KIND_START   = 3'd1,
		KIND_STOP    = 3'd2,
		KIND_WRITE   = 3'd3,
		KIND_READ    = 3'd4,
		KIND_RECOVER = 3'd5,
		KIND_NOP     = 3'd6
	} kind_t;

	typedef enum logic [17:0] {
		PH_IDLE  = 18'h00001,
		PH_ST_H1 = 18'h00002,
		PH_ST_HI = 18'h00004,
		PH_ST_H2 = 18'h00008,
		PH_ST_H3 = 18'h00010,
		PH_SP_H1 = 18'h00020,
		PH_SP_HI = 18'h00040,
		PH_SP_H2 = 18'h00080,
		PH_WR_H  = 18'h00100,
		PH_WR_HI = 18'h00200,
		PH_WA_H  = 18'h00400,
		PH_WA_HI = 18'h00800,
		PH_RD_H  = 18'h01000,
		PH_RD_HI = 18'h02000,
		PH_RA_H  = 18'h04000,
		PH_RA_HI = 18'h08000,
		PH_RC_HI = 18'h10000,
		PH_RC_H  = 18'h20000
	} phase_t;

	typedef enum logic [1:0] {
		WAIT_PENDING = 2'd0,
		WAIT_HIGH    = 2'd1,
		WAIT_TIMEOUT = 2'd2
	} wait_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       scl;
		logic       sda;
	} item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       done;
		status_t    status;
		logic [7:0] rx_byte;
		logic       busy;
	} result_t;

	typedef struct packed {
		logic [HALF_W-1:0] half_period;
		logic [TMO_W-1:0]  stretch_tmo;
	} cfg_t;

endpackage

// ===== hdl/i2cm_front.sv =====
// Front end of the I2C master bit engine: classifies incoming transactions
// and keeps them in a two-entry queue for the sequencer.
// Depends on i2cm_pkg.
module i2cm_front import i2cm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       req_type,
	input  logic [2:0] cmd,
	input  logic [7:0] tx_byte,
	input  logic       send_ack,
	input  logic       scl_in,
	input  logic       sda_in,
	output logic       q_empty,
	input  logic       q_pop,
	output item_t      q_item
);

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	item_t      item_in;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		item_in.tx_byte  = tx_byte;
		item_in.send_ack = send_ack;
		item_in.scl      = scl_in;
		item_in.sda      = sda_in;
		if (!req_type) begin
			item_in.kind = KIND_TICK;
		end else begin
			case (cmd)
				CMD_START:   item_in.kind = KIND_START;
				CMD_STOP:    item_in.kind = KIND_STOP;
				CMD_WRITE:   item_in.kind = KIND_WRITE;
				CMD_READ:    item_in.kind = KIND_READ;
				CMD_RECOVER: item_in.kind = KIND_RECOVER;
				default:     item_in.kind = KIND_NOP;
			endcase
		end
	end

	assign full    = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = q_pop && !q_empty;
	assign q_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/i2cm_seq.sv =====
// Back end of the I2C master bit engine: the bit-timing sequencer that drives
// SCL and SDA, one queued transaction per cycle while take is high. Depends on i2cm_pkg.
module i2cm_seq import i2cm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    take,
	input  item_t   item,
	output result_t res
);

	phase_t            phase_q, phase_n;
	logic [3:0]        bc_q, bc_n, bc_inc;
	logic [7:0]        sh_q, sh_n;
	logic [HALF_W-1:0] hold_q, hold_n, hold_inc, eff_half;
	logic [TMO_W-1:0]  str_q, str_n;
	logic              scl_low_q, scl_low_n;
	logic              sda_low_q, sda_low_n;
	logic              ack_q, ack_n;
	logic              hold_done;
	wait_t             wt;
	logic              done;
	status_t           stat;
	logic [7:0]        rx;

	assign eff_half  = (cfg.half_period == '0) ? HALF_W'(1) : cfg.half_period;
	assign hold_inc  = hold_q + HALF_W'(1);
	assign hold_done = (hold_inc >= eff_half);
	assign bc_inc    = bc_q + 4'd1;

	always_comb begin
		if (hold_q < eff_half) begin
			wt = WAIT_PENDING;
		end else if (item.scl) begin
			wt = WAIT_HIGH;
		end else if (str_q >= cfg.stretch_tmo) begin
			wt = WAIT_TIMEOUT;
		end else begin
			wt = WAIT_PENDING;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		bc_n      = bc_q;
		sh_n      = sh_q;
		hold_n    = hold_q;
		str_n     = str_q;
		scl_low_n = scl_low_q;
		sda_low_n = sda_low_q;
		ack_n     = ack_q;
		done      = 1'b0;
		stat      = ST_OK;
		rx        = 8'd0;

		if (item.kind != KIND_TICK) begin
			if (phase_q != PH_IDLE) begin
				stat = ST_BUSY;
			end else begin
				bc_n   = 4'd0;
				hold_n = '0;
				str_n  = '0;
				case (item.kind)
					KIND_START: begin
						sda_low_n = 1'b0;
						phase_n   = PH_ST_H1;
					end
					KIND_STOP: begin
						sda_low_n = 1'b1;
						phase_n   = PH_SP_H1;
					end
					KIND_WRITE: begin
						sda_low_n = ~item.tx_byte[7];
						sh_n      = {item.tx_byte[6:0], 1'b0};
						phase_n   = PH_WR_H;
					end
					KIND_READ: begin
						sda_low_n = 1'b0;
						sh_n      = 8'd0;
						ack_n     = item.send_ack;
						phase_n   = PH_RD_H;
					end
					KIND_RECOVER: begin
						sda_low_n = 1'b0;
						scl_low_n = 1'b0;
						phase_n   = PH_RC_HI;
					end
					default: begin
						done = 1'b1;
					end
				endcase
			end
		end else if (phase_q != PH_IDLE) begin
			// Released-SCL phases share the hold-then-wait counting.
			if (phase_q inside {PH_ST_HI, PH_SP_HI, PH_WR_HI, PH_WA_HI, PH_RD_HI,
					PH_RA_HI, PH_RC_HI}) begin
				if (hold_q < eff_half) begin
					hold_n = hold_inc;
				end else if (wt == WAIT_PENDING) begin
					str_n = str_q + TMO_W'(1);
				end
			end else begin
				hold_n = hold_inc;
			end

			case (phase_q)
				PH_ST_H1, PH_SP_H1, PH_WR_H, PH_WA_H, PH_RD_H, PH_RA_H: begin
					if (hold_done) begin
						scl_low_n = 1'b0;
						hold_n    = '0;
						str_n     = '0;
						case (phase_q)
							PH_ST_H1: phase_n = PH_ST_HI;
							PH_SP_H1: phase_n = PH_SP_HI;
							PH_WR_H:  phase_n = PH_WR_HI;
							PH_WA_H:  phase_n = PH_WA_HI;
							PH_RD_H:  phase_n = PH_RD_HI;
							default:  phase_n = PH_RA_HI;
						endcase
					end
				end
				PH_ST_HI: begin
					if (wt == WAIT_TIMEOUT) begin
						stat = ST_TIMEOUT;
						done = 1'b1;
					end else if (wt == WAIT_HIGH) begin
						sda_low_n = 1'b1;
						phase_n   = PH_ST_H2;
						hold_n    = '0;
						str_n     = '0;
					end
				end
				PH_ST_H2: begin
					if (hold_done) begin
						scl_low_n = 1'b1;
						phase_n   = PH_ST_H3;
						hold_n    = '0;
						str_n     = '0;
					end
				end
				PH_ST_H3, PH_SP_H2: begin
					done = hold_done;
				end
				PH_SP_HI: begin
					if (wt != WAIT_PENDING) begin
						sda_low_n = 1'b0;
						phase_n   = PH_SP_H2;
						hold_n    = '0;
						str_n     = '0;
					end
				end
				PH_WR_HI: begin
					if (wt == WAIT_TIMEOUT) begin
						stat = ST_TIMEOUT;
						done = 1'b1;
					end else if (wt == WAIT_HIGH) begin
						scl_low_n = 1'b1;
						bc_n      = bc_inc;
						hold_n    = '0;
						str_n     = '0;
						if (bc_inc < BITS_PER_BYTE) begin
							sda_low_n = ~sh_q[7];
							sh_n      = {sh_q[6:0], 1'b0};
							phase_n   = PH_WR_H;
						end else begin
							sda_low_n = 1'b0;
							phase_n   = PH_WA_H;
						end
					end
				end
				PH_WA_HI: begin
					if (wt == WAIT_TIMEOUT) begin
						stat = ST_TIMEOUT;
						done = 1'b1;
					end else if (wt == WAIT_HIGH) begin
						scl_low_n = 1'b1;
						stat      = item.sda ? ST_NACK : ST_OK;
						done      = 1'b1;
					end
				end
				PH_RD_HI: begin
					if (wt == WAIT_TIMEOUT) begin
						stat = ST_TIMEOUT;
						done = 1'b1;
					end else if (wt == WAIT_HIGH) begin
						sh_n      = {sh_q[6:0], item.sda};
						scl_low_n = 1'b1;
						bc_n      = bc_inc;
						hold_n    = '0;
						str_n     = '0;
						if (bc_inc < BITS_PER_BYTE) begin
							phase_n = PH_RD_H;
						end else begin
							sda_low_n = ack_q;
							phase_n   = PH_RA_H;
						end
					end
				end
				PH_RA_HI: begin
					if (wt == WAIT_TIMEOUT) begin
						stat = ST_TIMEOUT;
						done = 1'b1;
					end else if (wt == WAIT_HIGH) begin
						scl_low_n = 1'b1;
						rx        = sh_q;
						done      = 1'b1;
					end
				end
				PH_RC_HI: begin
					if (wt != WAIT_PENDING) begin
						scl_low_n = 1'b1;
						phase_n   = PH_RC_H;
						hold_n    = '0;
						str_n     = '0;
					end
				end
				PH_RC_H: begin
					if (hold_done) begin
						bc_n   = bc_inc;
						hold_n = '0;
						str_n  = '0;
						if (bc_inc < RECOVER_PULSES) begin
							scl_low_n = 1'b0;
							phase_n   = PH_RC_HI;
						end else begin
							sda_low_n = 1'b1;
							phase_n   = PH_SP_H1;
						end
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
			if (done) begin
				phase_n = PH_IDLE;
			end
		end
	end

	assign res.scl_out = ~scl_low_n;
	assign res.sda_out = ~sda_low_n;
	assign res.done    = done;
	assign res.status  = stat;
	assign res.rx_byte = rx;
	assign res.busy    = (phase_n != PH_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bc_q      <= 4'd0;
			sh_q      <= 8'd0;
			hold_q    <= '0;
			str_q     <= '0;
			scl_low_q <= 1'b0;
			sda_low_q <= 1'b0;
			ack_q     <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_n;
			bc_q      <= bc_n;
			sh_q      <= sh_n;
			hold_q    <= hold_n;
			str_q     <= str_n;
			scl_low_q <= scl_low_n;
			sda_low_q <= sda_low_n;
			ack_q     <= ack_n;
		end
	end

endmodule

// ===== hdl/i2cm_resq.sv =====
// Two-entry result queue of the I2C master bit engine; it parts the
// sequencer from the consumer of results. Depends on i2cm_pkg.
module i2cm_resq import i2cm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  result_t wr_data,
	output logic    q_full,
	output logic    empty,
	input  logic    pop,
	output result_t rd_data
);

	result_t    mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign q_full  = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = wr_en && !q_full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/i2c_master_bit_engine.sv =====
// I2C master bit engine top level: front queue, bit sequencer, result queue.
// A transaction's result is written into the result queue at the edge that accepts it
// from the front queue, so it can then be popped; a full result queue holds the sequencer.
// Throughput: one transaction per cycle while one is queued and the result queue has room.
// Reset: arst_n clears the queues and the sequencer to idle with both lines released,
// and loads the half period and stretch timeout registers with 50 and 1000.
module i2c_master_bit_engine import i2cm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             req_type,
	input  logic [2:0]       cmd,
	input  logic [7:0]       tx_byte,
	input  logic             send_ack,
	input  logic             scl_in,
	input  logic             sda_in,
	output logic             empty,
	input  logic             pop,
	output logic             scl_out,
	output logic             sda_out,
	output logic             done_res,
	output logic [1:0]       status,
	output logic [7:0]       rx_byte,
	output logic             busy_res,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	logic    cq_empty;
	item_t   cq_item;
	logic    rq_full;
	logic    take;
	result_t seq_res;
	result_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period <= HALF_RESET;
			cfg_q.stretch_tmo <= TMO_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_HALF_PERIOD: cfg_q.half_period <= cfg_wdata[HALF_W-1:0];
				REG_STRETCH_TMO: cfg_q.stretch_tmo <= cfg_wdata[TMO_W-1:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	assign take = !cq_empty && !rq_full;

	i2cm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.cmd      (cmd),
		.tx_byte  (tx_byte),
		.send_ack (send_ack),
		.scl_in   (scl_in),
		.sda_in   (sda_in),
		.q_empty  (cq_empty),
		.q_pop    (take),
		.q_item   (cq_item)
	);

	i2cm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.take   (take),
		.item   (cq_item),
		.res    (seq_res)
	);

	i2cm_resq u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_data (seq_res),
		.q_full  (rq_full),
		.empty   (empty),
		.pop     (pop),
		.rd_data (out_res)
	);

	assign scl_out  = out_res.scl_out;
	assign sda_out  = out_res.sda_out;
	assign done_res = out_res.done;
	assign status   = out_res.status;
	assign rx_byte  = out_res.rx_byte;
	assign busy_res = out_res.busy;

	a_take_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !rq_full && !cq_empty)
		else $error("sequencer stepped without a queued transaction or result room");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && done_res) |-> !busy_res)
		else $error("finished command still reported busy");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_BUSY) |-> (!done_res && busy_res))
		else $error("rejection reported while idle or finishing");

	a_rx_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !done_res) |-> (rx_byte == 8'd0))
		else $error("read data shown without a finished command");

endmodule
